// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers shared by the RTL; they compile away when SYNTH
// is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Implication or plain property, checked at every rising edge out of reset.
`define ASSERT_CLKD(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Condition that must never be seen at a rising edge out of reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLKD(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// ===== src/brmb_pkg.sv =====
// ---------------------------------------------------------------------------
// brmb_pkg
// Sizes, command codes and status codes of the byte ring message buffer.
// ---------------------------------------------------------------------------
package brmb_pkg;

  localparam int RING_DEPTH = 4096;
  localparam int READ_BURST = 64;

  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam int CAP_W = IDX_W + 1;
  localparam int LEN_W = 13;
  localparam int CNT_W = 7;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  typedef enum logic [1:0] {
    ST_WR_OK   = 2'd0,
    ST_WR_REJ  = 2'd1,
    ST_RD_BYTE = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

endpackage

// ===== src/byte_ring_message_buffer.sv =====
// ---------------------------------------------------------------------------
// byte_ring_message_buffer
// Circular byte buffer holding whole messages, one slot always kept empty.
// ---------------------------------------------------------------------------
// Usage. Items enter on the in_valid_i / in_ready_o channel. A write item
// carries one message byte; the first byte of a message also carries its
// length. A whole message is admitted only if its length is nonzero, fits the
// capacity and is below the free space, otherwise all of its bytes are
// dropped. One status item leaves on the out_valid_o / out_ready_i channel
// after the last byte, in the cycle after that byte is accepted. A read item
// returns up to 64 committed bytes, one output item per byte, the final one
// flagged with the byte count; an empty ring gives a single empty status.
// Throughput: write bytes are taken one per cycle. A read runs through the
// single read port of the byte store one address per cycle; each byte passes
// the store read register and then the output register, and the next item is
// taken once the last byte has left the store read register. When the
// receiver stalls, the output register and the store read register hold
// their data and the read sequencer waits; no item is accepted until the
// output register can take a result. Reset empties the ring and sets the
// capacity to 4096. The byte store is not cleared: only committed bytes are
// ever read. A capacity write empties the ring as well.
// ---------------------------------------------------------------------------
module byte_ring_message_buffer
  import brmb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // Capacity register
  input  logic             cfg_wr_en_i,
  input  logic [CAP_W-1:0] cfg_wr_data_i,
  // Input items
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             command_i,
  input  logic [7:0]       data_byte_i,
  input  logic [LEN_W-1:0] message_length_i,
  input  logic             first_of_message_i,
  // Result items
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [1:0]       status_o,
  output logic [7:0]       read_byte_o,
  output logic             last_of_run_o,
  output logic [CNT_W-1:0] read_count_o
);

  `include "assert_macros.svh"

  // Advance a ring index by one, wrapping at the capacity in use.
  function automatic logic [IDX_W-1:0] inc_wrap(input logic [IDX_W-1:0] idx,
                                                 input logic [CAP_W-1:0] cap);
    logic [CAP_W-1:0] sum;
    sum = {1'b0, idx} + CAP_W'(1);
    return (sum >= cap) ? '0 : sum[IDX_W-1:0];
  endfunction

  // Ring control state.
  logic [CAP_W-1:0] cap_q, cap_d;
  logic [IDX_W-1:0] wr_idx_q, wr_idx_d;
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
  logic [IDX_W-1:0] pend_q, pend_d;
  logic [LEN_W-1:0] remain_q, remain_d;
  logic             admit_q, admit_d;

  // Read burst sequencer.
  logic [CNT_W-1:0] burst_left_q, burst_left_d;
  logic [CNT_W-1:0] burst_n_q, burst_n_d;
  logic             rd_pend_q, rd_pend_d;
  logic             pend_last_q;

  // Byte store and its registered read data.
  logic [7:0]       store_mem [RING_DEPTH];
  logic [7:0]       rd_data_q;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic             rd_issue;

  // Output register.
  logic             out_valid_q;
  status_e          out_status_q;
  logic [7:0]       out_byte_q;
  logic             out_last_q;
  logic [CNT_W-1:0] out_cnt_q;

  // Handshake and datapath helpers.
  logic             in_acc;
  logic             load_ok;
  logic             burst_act;
  logic [CAP_W-1:0] used;
  logic [CAP_W-1:0] space_left;
  logic             admit_ok;
  logic [CNT_W-1:0] req_n;
  logic [CNT_W-1:0] burst_eff;
  logic             wr_active;
  logic             admit_new;
  logic [LEN_W-1:0] remain_base;
  logic [IDX_W-1:0] pos_base;
  logic [IDX_W-1:0] pos_next;
  logic             acc_res;
  status_e          acc_status;
  logic [CAP_W-1:0] cap_clamped;

  assign burst_act  = (burst_left_q != '0);
  assign load_ok    = !out_valid_q || out_ready_i;
  assign in_ready_o = !burst_act && !rd_pend_q && load_ok;
  assign in_acc     = in_valid_i && in_ready_o;

  // A new store read is started while the previous byte is either absent or
  // leaving for the output register in this same cycle.
  assign rd_issue = burst_act && (!rd_pend_q || load_ok);

  // Occupancy of the committed part of the ring.
  always_comb begin
    if (wr_idx_q >= rd_idx_q) begin
      used = {1'b0, wr_idx_q} - {1'b0, rd_idx_q};
    end else begin
      used = cap_q - ({1'b0, rd_idx_q} - {1'b0, wr_idx_q});
    end
  end

  assign space_left = cap_q - used;
  assign admit_ok   = (message_length_i <= cap_q) && (message_length_i < space_left);

  // Read length saturated to the burst limit, then to what is committed.
  assign req_n     = (message_length_i > LEN_W'(READ_BURST)) ? CNT_W'(READ_BURST)
                                                             : message_length_i[CNT_W-1:0];
  assign burst_eff = (used < CAP_W'(req_n)) ? used[CNT_W-1:0] : req_n;

  always_comb begin
    if (cfg_wr_data_i < CAP_W'(2)) begin
      cap_clamped = CAP_W'(2);
    end else if (cfg_wr_data_i > CAP_W'(RING_DEPTH)) begin
      cap_clamped = CAP_W'(RING_DEPTH);
    end else begin
      cap_clamped = cfg_wr_data_i;
    end
  end

  // Next state of the ring and the burst sequencer.
  always_comb begin
    cap_d        = cap_q;
    wr_idx_d     = wr_idx_q;
    rd_idx_d     = rd_idx_q;
    pend_d       = pend_q;
    remain_d     = remain_q;
    admit_d      = admit_q;
    burst_left_d = burst_left_q;
    burst_n_d    = burst_n_q;
    mem_we       = 1'b0;
    mem_waddr    = pend_q;
    acc_res      = 1'b0;
    acc_status   = ST_WR_OK;
    wr_active    = 1'b0;
    admit_new    = admit_q;
    remain_base  = remain_q;
    pos_base     = pend_q;
    pos_next     = pend_q;

    if (cfg_wr_en_i) begin
      cap_d        = cap_clamped;
      wr_idx_d     = '0;
      rd_idx_d     = '0;
      pend_d       = '0;
      remain_d     = '0;
      admit_d      = 1'b0;
      burst_left_d = '0;
    end else if (in_acc) begin
      if (command_i == CMD_WRITE) begin
        if (first_of_message_i) begin
          if (message_length_i == '0) begin
            remain_d   = '0;
            admit_d    = 1'b0;
            acc_res    = 1'b1;
            acc_status = ST_WR_REJ;
          end else begin
            // A new first byte abandons any message still open.
            wr_active   = 1'b1;
            admit_new   = admit_ok;
            remain_base = message_length_i;
            pos_base    = wr_idx_q;
          end
        end else if (remain_q != '0) begin
          wr_active = 1'b1;
        end

        if (wr_active) begin
          pos_next  = admit_new ? inc_wrap(pos_base, cap_q) : pos_base;
          mem_we    = admit_new;
          mem_waddr = pos_base;
          pend_d    = pos_next;
          remain_d  = remain_base - LEN_W'(1);
          if (remain_d == '0) begin
            // Last byte: commit an admitted message and report.
            acc_res = 1'b1;
            admit_d = 1'b0;
            if (admit_new) begin
              wr_idx_d   = pos_next;
              acc_status = ST_WR_OK;
            end else begin
              acc_status = ST_WR_REJ;
            end
          end else begin
            admit_d = admit_new;
          end
        end
      end else begin
        if (req_n == '0 || used == '0) begin
          acc_res    = 1'b1;
          acc_status = ST_EMPTY;
        end else begin
          burst_left_d = burst_eff;
          burst_n_d    = burst_eff;
        end
      end
    end

    if (rd_issue) begin
      rd_idx_d     = inc_wrap(rd_idx_q, cap_q);
      burst_left_d = burst_left_q - CNT_W'(1);
    end
  end

  always_comb begin
    if (rd_issue) begin
      rd_pend_d = 1'b1;
    end else if (rd_pend_q && load_ok) begin
      rd_pend_d = 1'b0;
    end else begin
      rd_pend_d = rd_pend_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q        <= CAP_W'(RING_DEPTH);
      wr_idx_q     <= '0;
      rd_idx_q     <= '0;
      pend_q       <= '0;
      remain_q     <= '0;
      admit_q      <= 1'b0;
      burst_left_q <= '0;
      burst_n_q    <= '0;
      rd_pend_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      cap_q        <= cap_d;
      wr_idx_q     <= wr_idx_d;
      rd_idx_q     <= rd_idx_d;
      pend_q       <= pend_d;
      remain_q     <= remain_d;
      admit_q      <= admit_d;
      burst_left_q <= burst_left_d;
      burst_n_q    <= burst_n_d;
      rd_pend_q    <= rd_pend_d;
      if ((rd_pend_q && load_ok) || acc_res) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Byte store: written by admitted message bytes, read by the burst
  // sequencer. Input items are held off during a burst, so a write and a read
  // never fall in the same cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= data_byte_i;
    end
    if (rd_issue) begin
      rd_data_q   <= store_mem[rd_idx_q];
      pend_last_q <= (burst_left_q == CNT_W'(1));
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (rd_pend_q && load_ok) begin
      out_status_q <= ST_RD_BYTE;
      out_byte_q   <= rd_data_q;
      out_last_q   <= pend_last_q;
      out_cnt_q    <= pend_last_q ? burst_n_q : '0;
    end else if (acc_res) begin
      out_status_q <= acc_status;
      out_byte_q   <= '0;
      out_last_q   <= 1'b1;
      out_cnt_q    <= '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign read_byte_o   = out_byte_q;
  assign last_of_run_o = out_last_q;
  assign read_count_o  = out_cnt_q;

  `ASSERT_NEVER(a_no_accept_in_burst, clk_i, rst_ni, in_acc && (burst_act || rd_pend_q))
  `ASSERT_NEVER(a_used_below_cap, clk_i, rst_ni, used >= cap_q)
  `ASSERT_NEVER(a_idx_below_cap, clk_i, rst_ni,
                ({1'b0, rd_idx_q} >= cap_q) || ({1'b0, wr_idx_q} >= cap_q))
  `ASSERT_CLKD(a_stall_holds_byte, clk_i, rst_ni,
               (rd_pend_q && out_valid_q && !out_ready_i) |=> (rd_pend_q && $stable(rd_data_q)))
  `ASSERT_NEVER(a_store_one_access, clk_i, rst_ni, mem_we && rd_issue)

endmodule

// ===== sim/tb_byte_ring_message_buffer.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_byte_ring_message_buffer
// Self-checking testbench for the byte ring message buffer. Directed items
// cover the empty ring, byte extremes, rejection, abandoned messages, the
// smallest ring and capacity clamping. Output back-pressure and random
// traffic follow. A behavioural copy of the ring predicts every result item,
// which is compared field by field as it leaves the block.
// ---------------------------------------------------------------------------
module tb_byte_ring_message_buffer;
  import brmb_pkg::*;

  // One result item as it leaves the block.
  typedef struct packed {
    status_e          status;
    logic [7:0]       rd_byte;
    logic             last;
    logic [CNT_W-1:0] count;
  } ring_result_t;

  // Clock, reset and block inputs. Every input has a known value from time 0.
  logic             clk_i;
  logic             rst_ni             = 1'b0;
  logic             cfg_wr_en_i        = 1'b0;
  logic [CAP_W-1:0] cfg_wr_data_i      = '0;
  logic             in_valid_i         = 1'b0;
  logic             in_ready_o;
  logic             command_i          = CMD_WRITE;
  logic [7:0]       data_byte_i        = '0;
  logic [LEN_W-1:0] message_length_i   = '0;
  logic             first_of_message_i = 1'b0;
  logic             out_valid_o;
  logic             out_ready_i        = 1'b0;
  logic [1:0]       status_o;
  logic [7:0]       read_byte_o;
  logic             last_of_run_o;
  logic [CNT_W-1:0] read_count_o;

  // Result items predicted but not yet seen, oldest first.
  ring_result_t ring_results_due[$];
  int           fail_count     = 0;

  // Idling controls. The hold-off count is consumed by the receiver process,
  // which counts the cycles itself.
  bit           tx_idle_en     = 1'b1;
  bit           rx_idle_en     = 1'b1;
  int           rx_hold_cycles = 0;

  // Predictor state: the capacity register and a copy of the ring. Pointers
  // are one bit wider than an index so that they compare cleanly with the
  // capacity in use.
  logic [CAP_W-1:0] cap_reg   = CAP_W'(RING_DEPTH);
  logic [7:0]       ring_mem [RING_DEPTH];
  logic [CAP_W-1:0] wr_ptr    = '0;
  logic [CAP_W-1:0] rd_ptr    = '0;
  logic [CAP_W-1:0] pend_ptr  = '0;
  logic [LEN_W-1:0] bytes_left = '0;
  bit               admitted  = 1'b0;

  byte_ring_message_buffer u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_wr_en_i        (cfg_wr_en_i),
    .cfg_wr_data_i      (cfg_wr_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .command_i          (command_i),
    .data_byte_i        (data_byte_i),
    .message_length_i   (message_length_i),
    .first_of_message_i (first_of_message_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .status_o           (status_o),
    .read_byte_o        (read_byte_o),
    .last_of_run_o      (last_of_run_o),
    .read_count_o       (read_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ------------------------------------------------------------------------
  // Ring predictor
  // ------------------------------------------------------------------------

  // The register holds 13 bits, but the ring only ever uses between two
  // slots and its full depth.
  function automatic int capacity_in_use();
    if (cap_reg < 2) begin
      return 2;
    end
    if (cap_reg > RING_DEPTH) begin
      return RING_DEPTH;
    end
    return int'(cap_reg);
  endfunction

  // Committed bytes between the read and write pointers.
  function automatic int ring_fill(input int cap);
    if (wr_ptr >= rd_ptr) begin
      return int'(wr_ptr) - int'(rd_ptr);
    end
    return cap - (int'(rd_ptr) - int'(wr_ptr));
  endfunction

  function automatic void clear_ring();
    wr_ptr     = '0;
    rd_ptr     = '0;
    pend_ptr   = '0;
    bytes_left = '0;
    admitted   = 1'b0;
  endfunction

  function automatic void push_result(input status_e st, input logic [7:0] b,
                                      input logic last, input int cnt);
    ring_result_t r;
    r.status  = st;
    r.rd_byte = b;
    r.last    = last;
    r.count   = CNT_W'(cnt);
    ring_results_due.push_back(r);
  endfunction

  // Works out the result items that one accepted input item causes.
  function automatic void predict_ring_item(input logic cmd, input logic [7:0] data,
                                            input logic [LEN_W-1:0] len,
                                            input logic first);
    int cap;
    int fill;
    int n;
    int k;
    bit last_byte;
    cap = capacity_in_use();
    if (wr_ptr >= cap || rd_ptr >= cap || pend_ptr >= cap) begin
      clear_ring();
    end
    if (cmd == CMD_WRITE) begin
      if (first) begin
        // A zero length is turned away on the spot and closes any open message.
        if (len == 0) begin
          bytes_left = '0;
          admitted   = 1'b0;
          push_result(ST_WR_REJ, 8'h00, 1'b1, 0);
          return;
        end
        fill       = ring_fill(cap);
        admitted   = (len <= cap) && (len < cap - fill);
        bytes_left = len;
        pend_ptr   = wr_ptr;
      end else if (bytes_left == 0) begin
        // A continuation byte with no message open is simply dropped.
        return;
      end
      if (admitted) begin
        ring_mem[pend_ptr] = data;
        pend_ptr = (pend_ptr + 1 >= cap) ? '0 : pend_ptr + 1'b1;
      end
      bytes_left = bytes_left - 1'b1;
      if (bytes_left != 0) begin
        return;
      end
      if (admitted) begin
        wr_ptr   = pend_ptr;
        admitted = 1'b0;
        push_result(ST_WR_OK, 8'h00, 1'b1, 0);
      end else begin
        push_result(ST_WR_REJ, 8'h00, 1'b1, 0);
      end
    end else begin
      fill = ring_fill(cap);
      n    = (len > READ_BURST) ? READ_BURST : int'(len);
      if (n == 0 || fill == 0) begin
        push_result(ST_EMPTY, 8'h00, 1'b1, 0);
        return;
      end
      if (n > fill) begin
        n = fill;
      end
      for (k = 0; k < n; k++) begin
        last_byte = (k + 1 == n);
        push_result(ST_RD_BYTE, ring_mem[rd_ptr], last_byte, last_byte ? n : 0);
        rd_ptr = (rd_ptr + 1 >= cap) ? '0 : rd_ptr + 1'b1;
      end
    end
  endfunction

  // ------------------------------------------------------------------------
  // Result side: random stalls, the long hold-off, and the checks.
  // ------------------------------------------------------------------------

  task automatic check_field(input string field_name, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %0d, actual %0d", $time, field_name, want, got);
      fail_count++;
    end
  endtask

  initial begin
    int stall;
    ring_result_t want;
    @(posedge clk_i);
    forever begin
      if (rx_hold_cycles > 0) begin
        stall = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        stall = rx_idle_en ? $urandom_range(0, 16) : 0;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      // Outputs are read straight after the edge, before the block updates
      // them, so they are the values that the edge accepted.
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      if (ring_results_due.size() == 0) begin
        $display("%0t ns: unexpected result item, status %0d byte %0d last %0d count %0d",
                 $time, status_o, read_byte_o, last_of_run_o, read_count_o);
        fail_count++;
      end else begin
        want = ring_results_due.pop_front();
        check_field("status", 8'(want.status), 8'(status_o));
        check_field("read_byte", want.rd_byte, read_byte_o);
        check_field("last_of_run", 8'(want.last), 8'(last_of_run_o));
        check_field("read_count", 8'(want.count), 8'(read_count_o));
      end
    end
  end

  // ------------------------------------------------------------------------
  // Input side
  // ------------------------------------------------------------------------

  // Offers one item and returns at the edge that accepts it. Valid is left
  // high, so a following item with no gap goes out back to back; a gap or a
  // drain lowers it first.
  task automatic send_item(input logic cmd, input logic [7:0] data,
                           input logic [LEN_W-1:0] len, input logic first);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    command_i          <= cmd;
    data_byte_i        <= data;
    message_length_i   <= len;
    first_of_message_i <= first;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    predict_ring_item(cmd, data, len, first);
  endtask

  // Sends the first n_bytes bytes of a message of the given length, with
  // random contents. The length field of continuation bytes is noise.
  task automatic send_message(input int len, input int n_bytes);
    int i;
    for (i = 0; i < n_bytes; i++) begin
      send_item(CMD_WRITE, 8'($urandom_range(0, 255)),
                (i == 0) ? LEN_W'(len) : LEN_W'($urandom_range(0, 4096)), i == 0);
    end
  endtask

  task automatic send_read(input int max_count);
    send_item(CMD_READ, 8'($urandom_range(0, 255)), LEN_W'(max_count),
              1'($urandom_range(0, 1)));
  endtask

  // Stops offering items, waits for every predicted result, then lets the
  // block run on for a while so that late or surplus items would show.
  task automatic drain_results(input int tail);
    in_valid_i <= 1'b0;
    while (ring_results_due.size() != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  // A capacity write also empties the ring, so it happens only when idle.
  task automatic write_capacity(input logic [CAP_W-1:0] value);
    drain_results(8);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= value;
    @(posedge clk_i);
    cfg_wr_en_i   <= 1'b0;
    cap_reg = value;
    clear_ring();
  endtask

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  // Out of reset: reads of an empty ring, a zero request, a stray
  // continuation byte and a zero-length message.
  task automatic test_empty_ring();
    send_read(5);
    send_read(0);
    send_item(CMD_WRITE, 8'hFF, LEN_W'(4096), 1'b0);
    send_message(0, 1);
  endtask

  // Byte extremes go in and come back; a zero request with data present is
  // still empty, and an oversized read is cut to the committed bytes.
  task automatic test_store_and_fetch();
    send_item(CMD_WRITE, 8'h00, LEN_W'(3), 1'b1);
    send_item(CMD_WRITE, 8'hFF, LEN_W'(0), 1'b0);
    send_item(CMD_WRITE, 8'h5A, LEN_W'(8191 & 4096), 1'b0);
    send_read(0);
    send_read(1);
    send_read(4096);
  endtask

  // A message that cannot fit is left open part-way, then a new first byte
  // abandons it; only the second message is committed.
  task automatic test_abandon_and_reject();
    send_message(4096, 3);
    send_message(2, 2);
    send_read(64);
  endtask

  // The smallest ring holds a single byte. A second byte does not fit, an
  // oversized message is counted off before it is rejected, and repeated use
  // makes the pointers wrap.
  task automatic test_tiny_ring();
    write_capacity(CAP_W'(2));
    send_message(1, 1);
    send_message(1, 1);
    send_message(3, 3);
    send_read(64);
    send_message(1, 1);
    send_read(1);
  endtask

  // Register values outside the usable range clamp to two slots or the full
  // depth; a capacity write throws away what the ring held.
  task automatic test_capacity_clamp();
    write_capacity(CAP_W'(0));
    send_message(2, 2);
    send_message(1, 1);
    write_capacity(CAP_W'(8191));
    send_read(4);
  endtask

  // The receiver stops for a long stretch while a full burst is read, so the
  // output stalls and the block refuses further items until it drains.
  task automatic test_output_backpressure();
    write_capacity(CAP_W'(RING_DEPTH));
    tx_idle_en     = 1'b0;
    rx_hold_cycles = 300;
    send_message(70, 70);
    send_read(100);
    send_read(64);
    send_message(2, 2);
    send_read(4);
    tx_idle_en     = 1'b1;
  endtask

  // One random step. Mostly whole messages and reads, with some rejected,
  // empty, stray and abandoned writes mixed in. Ignored stray bytes are not
  // counted.
  task automatic random_step(input int cap, inout int items);
    int pick;
    int len;
    int n_bytes;
    int sel;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      len = $urandom_range(1, (cap < 12) ? cap : 12);
      send_message(len, len);
      items += len;
    end else if (pick < 80) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        len = 0;
      end else if (sel == 1) begin
        len = $urandom_range(65, 4096);
      end else begin
        len = $urandom_range(1, 64);
      end
      send_read(len);
      items++;
    end else if (pick < 88 && cap <= 24) begin
      len = cap + $urandom_range(1, 3);
      send_message(len, len);
      items += len;
    end else if (pick < 93) begin
      send_message(0, 1);
      items++;
    end else if (pick < 97) begin
      send_item(CMD_WRITE, 8'($urandom_range(0, 255)), LEN_W'($urandom_range(0, 4096)),
                1'b0);
    end else begin
      len     = $urandom_range(2, 4096);
      n_bytes = $urandom_range(1, (len < 4) ? len - 1 : 3);
      send_message(len, n_bytes);
      items += n_bytes;
    end
  endtask

  // Random traffic over several capacities, the extremes among them, with
  // one phase of back-to-back items and one with a receiver that never waits.
  task automatic test_random_traffic();
    int caps [4];
    int items;
    int p;
    caps = '{RING_DEPTH, 2, $urandom_range(3, 24), $urandom_range(25, 300)};
    for (p = 0; p < 4; p++) begin
      write_capacity(CAP_W'(caps[p]));
      tx_idle_en = (p != 1);
      rx_idle_en = (p != 2);
      items = 0;
      while (items < 10) begin
        random_step(caps[p], items);
      end
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_empty_ring();
    test_store_and_fetch();
    test_abandon_and_reject();
    test_tiny_ring();
    test_capacity_clamp();
    test_output_backpressure();
    test_random_traffic();
    drain_results(80);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Guard against a hang: far beyond the slowest correct run.
  initial begin
    #(20_000_000);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/brmb_pkg.sv
src/byte_ring_message_buffer.sv
sim/tb_byte_ring_message_buffer.sv
